// ----- rtl/lmdd_pkg.sv -----
package lmdd_pkg;

  // Field widths of the request and result transactions.
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned THREAD_ID_W   = 3;
  localparam int unsigned RESOURCE_ID_W = 4;
  localparam int unsigned OWNER_ID_W    = 3;
  localparam int unsigned CYCLE_MASK_W  = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_ACQUIRE = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the presented request transaction
    logic root_step;  // pick the next unseen root
    logic walk_step;  // examine one neighbour or backtrack one level
    logic load_res;   // copy the search outcome into the result register
    logic load_zero;  // load an all-zero result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_search;  // presented item is a blocked request
    logic no_root;      // every node has been visited
    logic found;        // the current step hits a node on the path
    logic exhausted;    // the current root has no neighbours left
  } dp_status_t;

endpackage

// ----- rtl/lmdd_req_if.sv -----
interface lmdd_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [lmdd_pkg::ACTION_W-1:0]         action;
  logic [lmdd_pkg::THREAD_ID_W-1:0]      thread_id;
  logic [lmdd_pkg::RESOURCE_ID_W-1:0]    resource_id;

  modport source (output valid, action, thread_id, resource_id, input ready);
  modport sink (input valid, action, thread_id, resource_id, output ready);
endinterface

// ----- rtl/lmdd_res_if.sv -----
interface lmdd_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 blocked;
  logic [lmdd_pkg::OWNER_ID_W-1:0]      owner_id;
  logic                                 deadlock;
  logic [lmdd_pkg::CYCLE_MASK_W-1:0]    cycle_mask;

  modport source (output valid, blocked, owner_id, deadlock, cycle_mask, input ready);
  modport sink (input valid, blocked, owner_id, deadlock, cycle_mask, output ready);
endinterface

// ----- rtl/lock_manager_deadlock_detector_top.sv -----
// Timing: acquire, release, ignored items and requests for a free resource give their
// result in the cycle after acceptance; a blocked request gives its result once the search
// is over, which runs through the roots started, the descents to an unseen neighbour and
// the backtracks, and later still while an earlier result still waits to be taken.
// Throughput: one transaction at a time; the next is accepted once its result slot is free.
// Reset (asynchronous, active low) empties the wait-for graph and the ownership table.
module lock_manager_deadlock_detector_top #(
  parameter int unsigned THREADS   = 8,
  parameter int unsigned RESOURCES = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  lmdd_req_if.sink   req_i,
  lmdd_res_if.source res_o
);

  // The controller sequences each transaction: it accepts a request, then, for a
  // blocked request, alternates between choosing a fresh root and walking the
  // graph one edge per cycle, until a back edge is found or every node is seen.
  lmdd_pkg::ctrl_cmd_t  cmd;
  lmdd_pkg::dp_status_t sts;

  lmdd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the ownership table, the wait-for graph held as one row of
  // edges per thread, the explicit depth-first stack and the result register.
  lmdd_datapath #(
    .THREADS   (THREADS),
    .RESOURCES (RESOURCES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .action_i      (req_i.action),
    .thread_id_i   (req_i.thread_id),
    .resource_id_i (req_i.resource_id),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .blocked_o     (res_o.blocked),
    .owner_id_o    (res_o.owner_id),
    .deadlock_o    (res_o.deadlock),
    .cycle_mask_o  (res_o.cycle_mask)
  );

  // No new transaction is taken while a search is walking the graph.
  a_no_accept_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_step |-> !req_i.ready)
    else $error("request accepted during a graph walk");

  // A deadlock is only ever reported for a blocked request.
  a_deadlock_needs_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.deadlock) |-> res_o.blocked)
    else $error("deadlock reported without a blocked request");

  // An unblocked result carries no owner and no path.
  a_unblocked_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.blocked) |-> (res_o.owner_id == '0 && res_o.cycle_mask == '0))
    else $error("unblocked result carries owner or path bits");

  // A transaction needing no search produces its result in the next cycle.
  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && !sts.need_search) |=> res_o.valid)
    else $error("immediate result missing");

endmodule

// ----- rtl/lmdd_ctrl.sv -----
module lmdd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  lmdd_pkg::dp_status_t   sts_i,
  output lmdd_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROOT = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_search) begin
            state_d = ST_ROOT;
          end else begin
            cmd_o.load_zero = 1'b1;
          end
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        state_d = sts_i.no_root ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.found) begin
          state_d = ST_DONE;
        end else if (sts_i.exhausted) begin
          state_d = ST_ROOT;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_res = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_res || cmd_o.load_zero) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/lmdd_datapath.sv -----
module lmdd_datapath #(
  parameter int unsigned THREADS   = 8,
  parameter int unsigned RESOURCES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [lmdd_pkg::ACTION_W-1:0]         action_i,
  input  logic [lmdd_pkg::THREAD_ID_W-1:0]      thread_id_i,
  input  logic [lmdd_pkg::RESOURCE_ID_W-1:0]    resource_id_i,
  input  lmdd_pkg::ctrl_cmd_t                   cmd_i,
  output lmdd_pkg::dp_status_t                  sts_o,
  output logic                                  blocked_o,
  output logic [lmdd_pkg::OWNER_ID_W-1:0]       owner_id_o,
  output logic                                  deadlock_o,
  output logic [lmdd_pkg::CYCLE_MASK_W-1:0]     cycle_mask_o
);

  localparam int unsigned TW = $clog2(THREADS);
  localparam int unsigned RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int unsigned PW = $clog2(THREADS + 1);

  function automatic logic [TW-1:0] lowest_idx(input logic [THREADS-1:0] vec);
    logic [TW-1:0] idx;
    idx = '0;
    for (int i = THREADS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = TW'(i);
      end
    end
    return idx;
  endfunction

  // Wait-for graph and ownership table.
  logic [THREADS-1:0]   wait_q [THREADS];
  logic [RESOURCES-1:0] own_q  [THREADS];

  // Search state.
  logic [THREADS-1:0] seen_q, path_q;
  logic [TW-1:0]      cur_q;
  logic [PW-1:0]      ptr_q;
  logic [TW-1:0]      sp_q;
  logic [TW-1:0]      stk_node_q [THREADS];
  logic [PW-1:0]      stk_ptr_q  [THREADS];

  // Working result and result register.
  logic                                 blocked_q, deadlock_q;
  logic [lmdd_pkg::OWNER_ID_W-1:0]      owner_q;
  logic [lmdd_pkg::CYCLE_MASK_W-1:0]    mask_q;
  logic                                 out_blocked_q, out_deadlock_q;
  logic [lmdd_pkg::OWNER_ID_W-1:0]      out_owner_q;
  logic [lmdd_pkg::CYCLE_MASK_W-1:0]    out_mask_q;

  logic [TW-1:0]      tid_idx;
  logic [RW-1:0]      res_idx;
  logic               tid_ok, res_ok, item_ok;
  logic [THREADS-1:0] own_col;
  logic               own_any;
  logic [TW-1:0]      own_first;
  logic [THREADS-1:0] row, ge_mask, cand, unseen;
  logic               cand_any, nxt_on_path;
  logic [TW-1:0]      nxt, root;
  logic [TW-1:0]      sp_dec;
  logic [31:0]        path_wide;

  assign tid_idx = TW'(thread_id_i);
  assign res_idx = RW'(resource_id_i);
  assign tid_ok  = 32'(thread_id_i) < 32'(THREADS);
  assign res_ok  = 32'(resource_id_i) < 32'(RESOURCES);
  assign item_ok = tid_ok && res_ok;

  always_comb begin
    for (int t = 0; t < THREADS; t++) begin
      own_col[t] = own_q[t][res_idx];
    end
  end

  assign own_any   = |own_col;
  assign own_first = lowest_idx(own_col);

  // Neighbours of the current node not yet examined, skipping finished nodes.
  assign row = wait_q[cur_q];
  always_comb begin
    for (int i = 0; i < THREADS; i++) begin
      ge_mask[i] = 32'(i) >= 32'(ptr_q);
    end
  end
  assign cand        = row & ge_mask & (~seen_q | path_q);
  assign cand_any    = |cand;
  assign nxt         = lowest_idx(cand);
  assign nxt_on_path = path_q[nxt];
  assign unseen      = ~seen_q;
  assign root        = lowest_idx(unseen);
  assign sp_dec      = sp_q - TW'(1);
  assign path_wide   = 32'(path_q);

  always_comb begin
    sts_o.need_search = item_ok && (action_i == lmdd_pkg::ACT_REQUEST) && own_any;
    sts_o.no_root     = (unseen == '0);
    sts_o.found       = cand_any && nxt_on_path;
    sts_o.exhausted   = !cand_any && (sp_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < THREADS; t++) begin
        wait_q[t] <= '0;
        own_q[t]  <= '0;
      end
    end else if (cmd_i.accept && item_ok) begin
      unique case (action_i)
        lmdd_pkg::ACT_REQUEST: begin
          if (own_any) begin
            wait_q[tid_idx][own_first] <= 1'b1;
          end
        end
        lmdd_pkg::ACT_ACQUIRE: begin
          own_q[tid_idx][res_idx] <= 1'b1;
        end
        lmdd_pkg::ACT_RELEASE: begin
          own_q[tid_idx][res_idx] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blocked_q  <= sts_o.need_search;
      owner_q    <= sts_o.need_search ? lmdd_pkg::OWNER_ID_W'(own_first) : '0;
      deadlock_q <= 1'b0;
      mask_q     <= '0;
      seen_q     <= '0;
      path_q     <= '0;
    end
    if (cmd_i.root_step && !sts_o.no_root) begin
      cur_q        <= root;
      ptr_q        <= '0;
      sp_q         <= '0;
      seen_q[root] <= 1'b1;
      path_q[root] <= 1'b1;
    end
    if (cmd_i.walk_step) begin
      if (cand_any) begin
        if (nxt_on_path) begin
          deadlock_q <= 1'b1;
          mask_q     <= path_wide[lmdd_pkg::CYCLE_MASK_W-1:0];
        end else begin
          stk_node_q[sp_q] <= cur_q;
          stk_ptr_q[sp_q]  <= PW'(32'(nxt) + 32'd1);
          sp_q             <= sp_q + TW'(1);
          cur_q            <= nxt;
          ptr_q            <= '0;
          seen_q[nxt]      <= 1'b1;
          path_q[nxt]      <= 1'b1;
        end
      end else begin
        path_q[cur_q] <= 1'b0;
        if (sp_q != '0) begin
          cur_q <= stk_node_q[sp_dec];
          ptr_q <= stk_ptr_q[sp_dec];
          sp_q  <= sp_dec;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_zero) begin
      out_blocked_q  <= 1'b0;
      out_owner_q    <= '0;
      out_deadlock_q <= 1'b0;
      out_mask_q     <= '0;
    end else if (cmd_i.load_res) begin
      out_blocked_q  <= blocked_q;
      out_owner_q    <= owner_q;
      out_deadlock_q <= deadlock_q;
      out_mask_q     <= mask_q;
    end
  end

  assign blocked_o    = out_blocked_q;
  assign owner_id_o   = out_owner_q;
  assign deadlock_o   = out_deadlock_q;
  assign cycle_mask_o = out_mask_q;

endmodule

// ----- bench/tb_lock_manager_deadlock_detector_top.sv -----
module tb_lock_manager_deadlock_detector_top;

  localparam int unsigned THREADS    = 8;
  localparam int unsigned RESOURCES  = 16;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned DRAIN_WAIT = 100;
  localparam int unsigned SHOW_FAILS = 10;

  typedef logic [lmdd_pkg::ACTION_W-1:0]      action_t;
  typedef logic [lmdd_pkg::THREAD_ID_W-1:0]   thread_t;
  typedef logic [lmdd_pkg::RESOURCE_ID_W-1:0] resource_t;

  // An action code outside the defined set; the block must ignore it.
  localparam action_t ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic                              blocked;
    logic [lmdd_pkg::OWNER_ID_W-1:0]   owner_id;
    logic                              deadlock;
    logic [lmdd_pkg::CYCLE_MASK_W-1:0] cycle_mask;
  } lock_outcome_t;

  logic clk;
  logic rst_n;

  lmdd_req_if req_if ();
  lmdd_res_if res_if ();

  lock_manager_deadlock_detector_top #(
    .THREADS   (THREADS),
    .RESOURCES (RESOURCES)
  ) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Mirror of the block's state: who waits for whom, and who holds what.
  logic [THREADS-1:0]   waits_for      [THREADS];
  logic [RESOURCES-1:0] held_resources [THREADS];

  lock_outcome_t expected_outcomes [$];
  lock_outcome_t head_outcome;
  int unsigned   fail_count;
  int unsigned   send_idle_pct;
  int unsigned   ready_stall_pct;
  int unsigned   cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Lowest-numbered thread that holds the resource, or -1 when it is free.
  function automatic int first_holder(input resource_t res);
    int t;
    int holder;
    holder = -1;
    for (t = THREADS - 1; t >= 0; t--) begin
      if (held_resources[t][res]) holder = t;
    end
    return holder;
  endfunction

  // Depth-first search of the wait-for graph with an explicit stack. Roots and
  // neighbours are taken in ascending order; the first edge that leads back into
  // the current path ends the search and returns the path.
  function automatic logic search_wait_cycle(
    output logic [lmdd_pkg::CYCLE_MASK_W-1:0] path_mask
  );
    logic [THREADS-1:0] seen;
    logic [THREADS-1:0] path;
    int stack [THREADS];
    int next_nb [THREADS];
    int sp;
    int root;
    int node;
    int n;
    logic pushed;
    logic hit;
    seen      = '0;
    path      = '0;
    path_mask = '0;
    hit       = 1'b0;
    for (root = 0; root < THREADS; root++) begin
      if (!hit && !seen[root]) begin
        sp            = 1;
        stack[0]      = root;
        next_nb[root] = 0;
        seen[root]    = 1'b1;
        path[root]    = 1'b1;
        while (sp > 0 && !hit) begin
          node   = stack[sp - 1];
          pushed = 1'b0;
          for (n = next_nb[node]; n < THREADS; n++) begin
            if (!pushed && !hit && waits_for[node][n]) begin
              if (!seen[n]) begin
                next_nb[node] = n + 1;
                stack[sp]     = n;
                sp++;
                next_nb[n]    = 0;
                seen[n]       = 1'b1;
                path[n]       = 1'b1;
                pushed        = 1'b1;
              end else if (path[n]) begin
                path_mask = lmdd_pkg::CYCLE_MASK_W'(path);
                hit       = 1'b1;
              end
            end
          end
          if (!pushed && !hit) begin
            // Every neighbour done: leave this node and go back one level.
            path[node] = 1'b0;
            sp--;
          end
        end
      end
    end
    return hit;
  endfunction

  // Applies one accepted transaction to the mirrored state and returns its result.
  function automatic lock_outcome_t predict_lock_outcome(input action_t act, input thread_t tid,
                                                         input resource_t res);
    lock_outcome_t outcome;
    logic [lmdd_pkg::CYCLE_MASK_W-1:0] mask;
    int holder;
    outcome = '0;
    case (act)
      lmdd_pkg::ACT_REQUEST: begin
        holder = first_holder(res);
        if (holder >= 0) begin
          waits_for[tid][holder] = 1'b1;
          outcome.blocked        = 1'b1;
          outcome.owner_id       = lmdd_pkg::OWNER_ID_W'(holder);
          if (search_wait_cycle(mask)) begin
            outcome.deadlock   = 1'b1;
            outcome.cycle_mask = mask;
          end
        end
      end
      lmdd_pkg::ACT_ACQUIRE: held_resources[tid][res] = 1'b1;
      lmdd_pkg::ACT_RELEASE: held_resources[tid][res] = 1'b0;
      default: ;
    endcase
    return outcome;
  endfunction

  // Presents one transaction, with a random gap before it, and holds it until the
  // block takes it. Valid is left high afterwards so that back-to-back
  // transactions never lower and raise it within one time step.
  task automatic send_lock_op(input action_t act, input thread_t tid, input resource_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.thread_id   <= tid;
    req_if.resource_id <= res;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_outcomes.push_back(predict_lock_outcome(act, tid, res));
  endtask

  // Result side: ready stalls at the rate of the current phase.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_if.ready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Each result transaction is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_FAILS)
          $display("unexpected result: blocked=%0d owner=%0d deadlock=%0d mask=%02h",
                   res_if.blocked, res_if.owner_id, res_if.deadlock, res_if.cycle_mask);
      end else begin
        head_outcome = expected_outcomes.pop_front();
        if (head_outcome.blocked !== res_if.blocked ||
            head_outcome.owner_id !== res_if.owner_id ||
            head_outcome.deadlock !== res_if.deadlock ||
            head_outcome.cycle_mask !== res_if.cycle_mask) begin
          fail_count++;
          if (fail_count <= SHOW_FAILS) begin
            $display("mismatch: expected blocked=%0d owner=%0d deadlock=%0d mask=%02h",
                     head_outcome.blocked, head_outcome.owner_id, head_outcome.deadlock,
                     head_outcome.cycle_mask);
            $display("          got      blocked=%0d owner=%0d deadlock=%0d mask=%02h",
                     res_if.blocked, res_if.owner_id, res_if.deadlock, res_if.cycle_mask);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Free requests, unknown codes, shared ownership, repeated release and short
  // chains of waits. Every edge points from a lower to a higher thread, so no
  // cycle forms yet.
  task automatic test_directed_cases();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd0, 4'd0);
    send_lock_op(ACT_UNKNOWN, 3'd7, 4'd15);
    send_lock_op(lmdd_pkg::ACT_ACQUIRE, 3'd7, 4'd15);
    send_lock_op(lmdd_pkg::ACT_ACQUIRE, 3'd6, 4'd15);
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd0, 4'd15);
    send_lock_op(lmdd_pkg::ACT_RELEASE, 3'd6, 4'd15);
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd5, 4'd15);
    send_lock_op(lmdd_pkg::ACT_RELEASE, 3'd7, 4'd15);
    send_lock_op(lmdd_pkg::ACT_RELEASE, 3'd7, 4'd15);
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd3, 4'd15);
    send_lock_op(lmdd_pkg::ACT_ACQUIRE, 3'd3, 4'd0);
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd1, 4'd0);
    send_lock_op(lmdd_pkg::ACT_ACQUIRE, 3'd4, 4'd7);
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd3, 4'd7);
    send_lock_op(lmdd_pkg::ACT_REQUEST, 3'd0, 4'd7);
    send_lock_op(ACT_UNKNOWN, 3'd0, 4'd0);
    send_lock_op(lmdd_pkg::ACT_RELEASE, 3'd4, 4'd7);
    send_lock_op(lmdd_pkg::ACT_RELEASE, 3'd3, 4'd0);
  endtask

  // Random traffic in which a request only ever waits on a higher-numbered owner.
  // The graph stays acyclic, so every blocked request walks the whole graph.
  task automatic test_acyclic_waits(input int unsigned count);
    int unsigned roll;
    int holder;
    resource_t res;
    send_idle_pct   = 46;
    ready_stall_pct = 0;
    repeat (count) begin
      roll   = $urandom_range(99);
      res    = resource_t'($urandom_range(RESOURCES - 1));
      holder = first_holder(res);
      if (roll < 50 && holder != 0) begin
        if (holder < 0)
          send_lock_op(lmdd_pkg::ACT_REQUEST, thread_t'($urandom_range(THREADS - 1)), res);
        else
          send_lock_op(lmdd_pkg::ACT_REQUEST, thread_t'($urandom_range(holder - 1)), res);
      end else if (roll < 75 && holder >= 0) begin
        send_lock_op(lmdd_pkg::ACT_RELEASE, thread_t'(holder), res);
      end else begin
        send_lock_op(lmdd_pkg::ACT_ACQUIRE, thread_t'($urandom_range(THREADS - 1)), res);
      end
    end
  endtask

  // Rings of waiting threads of random size and membership, a single thread
  // waiting on itself among them. Each member first becomes the sole holder of
  // its resource, then asks for the next member's one.
  task automatic test_deadlock_rings(input int unsigned rings);
    int thr [THREADS];
    int rsc [RESOURCES];
    int k;
    int i;
    int j;
    int h;
    int tmp;
    send_idle_pct   = 0;
    ready_stall_pct = 46;
    for (i = 0; i < THREADS; i++) thr[i] = i;
    for (i = 0; i < RESOURCES; i++) rsc[i] = i;
    repeat (rings) begin
      for (i = THREADS - 1; i > 0; i--) begin
        j      = $urandom_range(i);
        tmp    = thr[i];
        thr[i] = thr[j];
        thr[j] = tmp;
      end
      for (i = RESOURCES - 1; i > 0; i--) begin
        j      = $urandom_range(i);
        tmp    = rsc[i];
        rsc[i] = rsc[j];
        rsc[j] = tmp;
      end
      k = $urandom_range(THREADS, 1);
      for (i = 0; i < k; i++) begin
        for (h = 0; h < THREADS; h++) begin
          if (held_resources[h][rsc[i]])
            send_lock_op(lmdd_pkg::ACT_RELEASE, thread_t'(h), resource_t'(rsc[i]));
        end
        send_lock_op(lmdd_pkg::ACT_ACQUIRE, thread_t'(thr[i]), resource_t'(rsc[i]));
      end
      for (i = 0; i < k; i++)
        send_lock_op(lmdd_pkg::ACT_REQUEST, thread_t'(thr[i]),
                     resource_t'(rsc[(i + 1) % k]));
      if ($urandom_range(3) == 0)
        send_lock_op(action_t'($urandom_range(3)), thread_t'($urandom_range(THREADS - 1)),
                     resource_t'($urandom_range(RESOURCES - 1)));
      for (i = 0; i < k; i++)
        send_lock_op(lmdd_pkg::ACT_RELEASE, thread_t'(thr[i]), resource_t'(rsc[i]));
    end
  endtask

  // Unrestricted random transactions, unknown action codes included.
  task automatic test_random_mix(input int unsigned count);
    int unsigned roll;
    action_t act;
    send_idle_pct   = 29;
    ready_stall_pct = 29;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 40)
        act = lmdd_pkg::ACT_REQUEST;
      else if (roll < 65)
        act = lmdd_pkg::ACT_ACQUIRE;
      else if (roll < 90)
        act = lmdd_pkg::ACT_RELEASE;
      else
        act = ACT_UNKNOWN;
      send_lock_op(act, thread_t'($urandom_range(THREADS - 1)),
                   resource_t'($urandom_range(RESOURCES - 1)));
    end
  endtask

  initial begin
    for (int t = 0; t < THREADS; t++) begin
      waits_for[t]      = '0;
      held_resources[t] = '0;
    end
    fail_count         = 0;
    send_idle_pct      = 0;
    ready_stall_pct    = 0;
    rst_n              <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.action      <= '0;
    req_if.thread_id   <= '0;
    req_if.resource_id <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_acyclic_waits(450);
    test_deadlock_rings(30);
    test_random_mix(850);

    req_if.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
